FILE: hw/rtl/ole_pkg.sv
package ole_pkg;

  localparam logic [2:0] OP_FRONT  = 3'd0;
  localparam logic [2:0] OP_BACK   = 3'd1;
  localparam logic [2:0] OP_INSERT = 3'd2;
  localparam logic [2:0] OP_READ   = 3'd3;
  localparam logic [2:0] OP_FIND   = 3'd4;
  localparam logic [2:0] OP_DELETE = 3'd5;
  localparam logic [2:0] OP_CLEAR  = 3'd6;
  localparam logic [2:0] OP_SORT   = 3'd7;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_RANGE    = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  localparam logic [1:0] CK_NONE = 2'd0;
  localparam logic [1:0] CK_INS  = 2'd1;
  localparam logic [1:0] CK_DEL  = 2'd2;
  localparam logic [1:0] CK_SORT = 2'd3;

  typedef struct packed {
    logic [1:0]  kind;
    logic        phase;
    logic        rd_mode;
    logic [31:0] value;
  } cell_cmd_t;

endpackage

FILE: hw/rtl/ordered_list_engine.sv
// Channel | Ports      | tdata fields, lowest bit up
// in      | in_t*      | operation[2:0] position[9:3] value[41:10], zero pad to 48
// out     | out_t*     | status[1:0] read_value[33:2] found_position[40:34]
//         |            | length[47:41] empty_res[48], zero pad to 56
// Every request except sort goes from an execute step to a finish step that registers the result.
// Sort puts a sort step between the two: one odd-even transposition pass of the cell row a cycle.
// Reset clears the state, the element count and the output valid; cell contents stay undefined until written.
// A new request is taken while the previous result waits in the output register.
// A held output stalls the engine in its final step.
module ordered_list_engine
  import ole_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // operation, position, value
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata   // status, read_value, found_position, length, empty_res
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = ((CW > 7) ? CW : 7) + 1;
  localparam int SW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] FULL_C = CW'(DEPTH);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_SORT = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0]       st_r, st_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [2:0]       op_r;
  logic [6:0]       pos_r;
  logic [31:0]      val_r;
  logic [1:0]       status_r, status_nxt;
  logic [DEPTH-1:0] hit_r;
  logic [SW-1:0]    sweep_r;
  logic             out_valid_r;
  logic [55:0]      out_data_r;

  cell_cmd_t        cmd;
  logic [AW-1:0]    at;
  logic [31:0]      cdata [DEPTH];
  logic [DEPTH-1:0] hit;
  logic [PW-1:0]    pos_x, cnt_x;
  logic             out_free;
  logic             in_acc;
  logic [31:0]      rd_val;
  logic [6:0]       found;

  assign in_acc    = in_tvalid && in_tready;
  assign in_tready = (st_r == S_IDLE);
  assign out_free  = !out_valid_r || out_tready;
  assign pos_x     = PW'(pos_r);
  assign cnt_x     = PW'(cnt_r);

  always_comb begin
    at = '0;
    case (op_r)
      OP_BACK: at = AW'(cnt_r);
      OP_FRONT: at = '0;
      default: at = AW'(pos_x - 1'b1);
    endcase
  end

  always_comb begin
    status_nxt = status_r;
    cnt_nxt    = cnt_r;
    cmd.kind   = CK_NONE;
    cmd.phase  = sweep_r[0];
    cmd.rd_mode = (op_r == OP_READ);
    cmd.value  = val_r;
    if (st_r == S_SORT) cmd.kind = CK_SORT;
    if (st_r == S_EXEC) begin
      status_nxt = ST_OK;
      unique case (op_r) inside
        OP_FRONT, OP_BACK: begin
          if (cnt_r >= FULL_C) status_nxt = ST_FULL;
          else begin
            cmd.kind = CK_INS;
            cnt_nxt  = cnt_r + 1'b1;
          end
        end
        OP_INSERT: begin
          if (pos_x < PW'(1) || pos_x > cnt_x + 1'b1) status_nxt = ST_RANGE;
          else if (cnt_r >= FULL_C) status_nxt = ST_FULL;
          else begin
            cmd.kind = CK_INS;
            cnt_nxt  = cnt_r + 1'b1;
          end
        end
        OP_READ: begin
          if (pos_x < PW'(1) || pos_x > cnt_x) status_nxt = ST_RANGE;
        end
        OP_FIND: status_nxt = ST_OK;
        OP_DELETE: begin
          if (pos_x < PW'(1) || pos_x > cnt_x) status_nxt = ST_RANGE;
          else begin
            cmd.kind = CK_DEL;
            cnt_nxt  = cnt_r - 1'b1;
          end
        end
        OP_CLEAR: cnt_nxt = '0;
        OP_SORT: status_nxt = ST_OK;
        default: status_nxt = ST_OK;
      endcase
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [31:0] l_d, r_d;
    if (i == 0) begin : g_l0
      assign l_d = '0;
    end else begin : g_l
      assign l_d = cdata[i-1];
    end
    if (i == DEPTH - 1) begin : g_rn
      assign r_d = '0;
    end else begin : g_r
      assign r_d = cdata[i+1];
    end
    ole_cell #(.IDX(i), .AW(AW), .CW(CW)) u_cell (
      .clk(clk), .cmd(cmd), .at(at), .count(cnt_r),
      .left_d(l_d), .right_d(r_d), .data(cdata[i]), .hit(hit[i])
    );
  end

  always_comb begin
    rd_val = '0;
    found  = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (hit_r[i]) found = 7'(i + 1);
      rd_val = rd_val | (cdata[i] & {32{hit_r[i]}});
    end
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_IDLE: if (in_acc) st_nxt = S_EXEC;
      S_EXEC: st_nxt = (op_r == OP_SORT) ? S_SORT : S_FIN;
      S_SORT: if (sweep_r == SW'(DEPTH - 1)) st_nxt = S_FIN;
      S_FIN:  if (out_free) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      sweep_r     <= '0;
    end else begin
      st_r    <= st_nxt;
      cnt_r   <= cnt_nxt;
      sweep_r <= (st_r == S_SORT) ? sweep_r + 1'b1 : '0;
      if (st_r == S_FIN && out_free) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r  <= in_tdata[2:0];
      pos_r <= in_tdata[9:3];
      val_r <= in_tdata[41:10];
    end
    if (st_r == S_EXEC) begin
      status_r <= status_nxt;
      hit_r    <= hit;
    end
    if (st_r == S_FIN && out_free) begin
      out_data_r <= '0;
      out_data_r[47:41] <= 7'(cnt_r);
      out_data_r[48]    <= (cnt_r == '0);
      if (op_r == OP_FIND) begin
        out_data_r[1:0]   <= (hit_r == '0) ? ST_NOTFOUND : ST_OK;
        out_data_r[40:34] <= found;
      end else begin
        out_data_r[1:0] <= status_r;
        if (op_r == OP_READ && status_r == ST_OK) out_data_r[33:2] <= rd_val;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef SYNTH
  a_acc_exec: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (st_r == S_EXEC))
    else $error("accepted request did not start execution");
  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= FULL_C)
    else $error("element count above depth");
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_FIN && status_r == ST_FULL && op_r != OP_FIND) |-> (cnt_r == FULL_C))
    else $error("full status with room left");
  a_cnt_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_SORT || st_r == S_FIN) |=> $stable(cnt_r))
    else $error("count changed outside execution");
`endif

endmodule

FILE: hw/rtl/ole_cell.sv
module ole_cell
  import ole_pkg::*;
#(
  parameter int IDX = 0,
  parameter int AW  = 6,
  parameter int CW  = 7
) (
  input  logic          clk,
  input  cell_cmd_t     cmd,
  input  logic [AW-1:0] at,
  input  logic [CW-1:0] count,
  input  logic [31:0]   left_d,
  input  logic [31:0]   right_d,
  output logic [31:0]   data,
  output logic          hit
);

  localparam logic [CW:0] IDX_C  = (CW+1)'(IDX);
  localparam logic [AW:0] IDX_A  = (AW+1)'(IDX);
  localparam logic        IS_ODD = 1'(IDX % 2);

  logic [31:0] data_r;
  logic [31:0] data_nxt;
  logic        in_list;
  logic        pair_right_ok;
  logic        pair_left_ok;

  assign in_list       = IDX_C < {1'b0, count};
  assign pair_right_ok = (IDX_C + 1'b1) < {1'b0, count};
  assign pair_left_ok  = (IDX > 0) && in_list;

  always_comb begin
    data_nxt = data_r;
    case (cmd.kind)
      CK_INS: begin
        if (IDX_A > {1'b0, at}) data_nxt = left_d;
        else if (IDX_A == {1'b0, at}) data_nxt = cmd.value;
      end
      CK_DEL: begin
        if (IDX_A >= {1'b0, at}) data_nxt = right_d;
      end
      CK_SORT: begin
        if (IS_ODD == cmd.phase) begin
          if (pair_right_ok && ($signed(data_r) > $signed(right_d))) data_nxt = right_d;
        end else begin
          if (pair_left_ok && ($signed(left_d) > $signed(data_r))) data_nxt = left_d;
        end
      end
      default: data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;
  assign hit  = in_list && (cmd.rd_mode ? (IDX_A == {1'b0, at}) : (data_r == cmd.value));

endmodule

FILE: test/ordered_list_engine_test.sv
module ordered_list_engine_test;
  import ole_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 64;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic        empty_res;
    logic [6:0]  length;
    logic [6:0]  found_position;
    logic [31:0] read_value;
    logic [1:0]  status;
  } list_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;

  logic [31:0]  model_store [DEPTH];
  int           model_count = 0;
  list_result_t pending_results [$];
  int           mismatch_count = 0;
  int           idle_cycles = 0;
  bit           calm_phase = 1'b0;
  bit           hold_receiver = 1'b0;
  bit           receiver_hold_done = 1'b0;

  ordered_list_engine #(.DEPTH(DEPTH)) i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always #4 clk = ~clk;

  function automatic list_result_t apply_request(logic [2:0] op, logic [6:0] pos,
                                                 logic [31:0] val);
    list_result_t r;
    logic [31:0]  cur;
    int           j;
    r = '0;
    r.status = ST_OK;
    case (op) inside
      OP_FRONT, OP_BACK, OP_INSERT: begin
        j = (op == OP_FRONT) ? 1 : (op == OP_BACK) ? model_count + 1 : int'(pos);
        if (j < 1 || j > model_count + 1) begin
          r.status = ST_RANGE;
        end else if (model_count >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          for (int k = model_count; k > j - 1; k--) model_store[k] = model_store[k - 1];
          model_store[j - 1] = val;
          model_count++;
        end
      end
      OP_READ: begin
        if (pos < 1 || pos > model_count) r.status = ST_RANGE;
        else r.read_value = model_store[pos - 1];
      end
      OP_FIND: begin
        r.status = ST_NOTFOUND;
        for (int k = 0; k < model_count; k++) begin
          if (model_store[k] == val && r.status == ST_NOTFOUND) begin
            r.status = ST_OK;
            r.found_position = 7'(k + 1);
          end
        end
      end
      OP_DELETE: begin
        if (pos < 1 || pos > model_count) begin
          r.status = ST_RANGE;
        end else begin
          for (int k = pos - 1; k + 1 < model_count; k++) model_store[k] = model_store[k + 1];
          model_count--;
        end
      end
      OP_CLEAR: model_count = 0;
      default: begin
        for (int k = 1; k < model_count; k++) begin
          cur = model_store[k];
          j = k;
          while (j > 0 && $signed(model_store[j - 1]) > $signed(cur)) begin
            model_store[j] = model_store[j - 1];
            j--;
          end
          model_store[j] = cur;
        end
      end
    endcase
    r.length = 7'(model_count);
    r.empty_res = (model_count == 0);
    return r;
  endfunction

  task automatic send_word(logic [2:0] op, logic [6:0] pos, logic [31:0] val);
    if (!calm_phase && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {6'd0, val, pos, op};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_results.push_back(apply_request(op, pos, val));
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 4))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom_range(0, 7) - 4;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [6:0] pick_position();
    if ($urandom_range(0, 9) == 0) return 7'($urandom_range(0, 127));
    return 7'($urandom_range(0, model_count + 1));
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (hold_receiver) begin
        out_tready <= 1'b0;
      end else if (calm_phase) begin
        out_tready <= 1'b1;
      end else if (!out_tready || $urandom_range(0, 9) == 0) begin
        out_tready <= (out_tready ? 1'b0 : ($urandom_range(0, 3) == 0));
      end
    end
  end

  always @(posedge clk) begin
    list_result_t got;
    list_result_t want;
    if (out_tvalid && out_tready) begin
      got = out_tdata[48:0];
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected result word %h", out_tdata);
      end else begin
        want = pending_results.pop_front();
        if (got !== want || out_tdata[55:49] !== 7'd0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: expected st=%0d rd=%h pos=%0d len=%0d emp=%0d, got %h",
                     want.status, want.read_value, want.found_position, want.length,
                     want.empty_res, out_tdata);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("ordered_list_engine_test failed");
      $finish;
    end
  end

  task automatic test_directed();
    send_word(OP_CLEAR, 0, 0);
    send_word(OP_SORT, 0, 0);
    send_word(OP_READ, 1, 0);
    send_word(OP_DELETE, 1, 0);
    send_word(OP_FIND, 0, 32'h5);
    send_word(OP_INSERT, 0, 32'h1);
    send_word(OP_INSERT, 2, 32'h1);
    send_word(OP_FRONT, 0, 32'h7fff_ffff);
    send_word(OP_BACK, 0, 32'h8000_0000);
    send_word(OP_INSERT, 2, 32'h0000_0003);
    send_word(OP_INSERT, 4, 32'h0000_0003);
    send_word(OP_INSERT, 5, 32'hffff_ffff);
    send_word(OP_INSERT, 127, 32'h1);
    send_word(OP_FIND, 0, 32'h3);
    send_word(OP_READ, 4, 0);
    send_word(OP_READ, 6, 0);
    send_word(OP_SORT, 0, 0);
    send_word(OP_READ, 1, 0);
    send_word(OP_DELETE, 5, 0);
    send_word(OP_DELETE, 0, 0);
    send_word(OP_READ, 127, 0);
  endtask

  task automatic test_full_store();
    send_word(OP_CLEAR, 0, 0);
    for (int k = 0; k < DEPTH; k++) send_word(k[0] ? OP_FRONT : OP_BACK, 0, $urandom);
    send_word(OP_FRONT, 0, 32'h1);
    send_word(OP_BACK, 0, 32'h1);
    send_word(OP_INSERT, 10, 32'h1);
    send_word(OP_INSERT, DEPTH + 2, 32'h1);
    send_word(OP_READ, DEPTH, 0);
    send_word(OP_SORT, 0, 0);
    send_word(OP_READ, 1, 0);
    send_word(OP_READ, DEPTH, 0);
    send_word(OP_DELETE, DEPTH, 0);
    send_word(OP_INSERT, DEPTH, 32'h2);
  endtask

  task automatic test_backpressure();
    hold_receiver = 1'b1;
    fork
      begin
        repeat (300) @(posedge clk);
        hold_receiver = 1'b0;
      end
      for (int k = 0; k < 12; k++) send_word(OP_FIND, 0, pick_value());
    join
  endtask

  task automatic test_random(int count);
    logic [2:0] op;
    for (int k = 0; k < count; k++) begin
      if (k > count - count / 8) calm_phase = 1'b1;
      case ($urandom_range(0, 19)) inside
        0, 1, 2: op = OP_BACK;
        3, 4: op = OP_FRONT;
        5, 6, 7: op = OP_INSERT;
        8, 9, 10: op = OP_READ;
        11, 12, 13: op = OP_FIND;
        14, 15, 16: op = OP_DELETE;
        17: op = ($urandom_range(0, 3) == 0) ? OP_CLEAR : OP_SORT;
        default: op = OP_SORT;
      endcase
      send_word(op, pick_position(), pick_value());
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_full_store();
    test_backpressure();
    test_random(1300);
    in_tvalid <= 1'b0;
    calm_phase = 1'b1;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DEPTH + 10) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("ordered_list_engine_test passed");
    end else begin
      $display("ordered_list_engine_test failed");
    end
    $finish;
  end

endmodule
